// ===== sv/hjs_pkg.sv =====
package hjs_pkg;

   localparam int MAX_COLS      = 64;
   localparam int VALUE_BITS    = 24;
   localparam int COL_BITS      = $clog2(MAX_COLS);
   localparam int COLS_EFF_BITS = $clog2(MAX_COLS + 1);
   localparam int ROW_BITS      = 16;
   localparam int CFG_COLS_BITS = 7;
   localparam int CSR_DATA_BITS = 16;
   localparam int SUM_BITS      = VALUE_BITS + 2;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int MIN_COLS      = 3;
   localparam int MIN_ROWS      = 3;

   typedef enum logic [0:0] {
      CSR_GRID_COLUMNS = 1'b0,
      CSR_GRID_ROWS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] new_value;
      logic [ROW_BITS-1:0]   out_row;
      logic [COL_BITS-1:0]   out_col;
      logic                  frame_last;
      logic [VALUE_BITS-1:0] max_increase;
   } result_type;

   typedef struct packed {
      logic first_valid;
      logic second_valid;
   } push_type;

   // one line store entry: row r-2 and row r-1 of the same column
   typedef struct packed {
      logic [VALUE_BITS-1:0] upper;
      logic [VALUE_BITS-1:0] middle;
   } line_pair_type;

endpackage

// ===== sv/heat_jacobi_stencil_sweep.sv =====
// One Jacobi sweep of a four-neighbor heat stencil over a grid streamed in
// raster order, values unsigned Q16.8. A cell item is taken every cycle
// unless the input stalls; once cell (r,c) arrives, the result for cell
// (r-1,c) is formed in the s1 registers and queued. On the last row each
// item also passes its own border cell through, so the output sets the pace.
// Results wait in a four-entry queue; the input stalls while that queue
// cannot take what the two items in flight may add. The two previous rows
// live in one 64 x 48-bit line store read one column ahead, so a single
// read port serves the stencil. max_increase is meaningful on frame_last.
// grid_columns is clamped to 3..64, grid_rows to at least 3.
module heat_jacobi_stencil_sweep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hjs_pkg::VALUE_BITS-1:0]    req_cell_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hjs_pkg::VALUE_BITS-1:0]    rsp_new_value,
   output logic [hjs_pkg::ROW_BITS-1:0]      rsp_out_row,
   output logic [hjs_pkg::COL_BITS-1:0]      rsp_out_col,
   output logic                              rsp_frame_last,
   output logic [hjs_pkg::VALUE_BITS-1:0]    rsp_max_increase,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  hjs_pkg::csr_index_type            csr_index,
   input  logic [hjs_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import hjs_pkg::*;

   logic [CFG_COLS_BITS-1:0] grid_columns_ff;
   logic [ROW_BITS-1:0]      grid_rows_ff;
   logic [COLS_EFF_BITS-1:0] cols_eff;
   logic [ROW_BITS-1:0]      rows_eff;

   logic [ROW_BITS-1:0]      row_count_ff;
   logic [COL_BITS-1:0]      col_count_ff;
   logic [VALUE_BITS-1:0]    running_max_ff;

   logic                     accept;
   logic                     last_row;
   logic                     row_end;
   logic                     frame_end;
   logic                     has_first;
   logic                     interior;
   logic [ROW_BITS-1:0]      er;
   logic [COL_BITS-1:0]      next_col;
   logic [COL_BITS-1:0]      rd_addr;
   logic [VALUE_BITS-1:0]    old_mid;

   line_pair_type            rd_pair;
   line_pair_type            wr_pair;
   logic [VALUE_BITS-1:0]    cur_up_ff;
   logic [VALUE_BITS-1:0]    cur_mid_ff;
   logic [VALUE_BITS-1:0]    left_ff;
   logic [VALUE_BITS-1:0]    col0_ff;

   logic                     s1_valid_ff;
   logic                     s1_first_ff;
   logic                     s1_second_ff;
   logic                     s1_interior_ff;
   logic                     s1_frame_end_ff;
   logic [VALUE_BITS-1:0]    s1_up_ff;
   logic [VALUE_BITS-1:0]    s1_left_ff;
   logic [VALUE_BITS-1:0]    s1_right_ff;
   logic [VALUE_BITS-1:0]    s1_x_ff;
   logic [VALUE_BITS-1:0]    s1_old_ff;
   logic [ROW_BITS-1:0]      s1_row_ff;
   logic [COL_BITS-1:0]      s1_col_ff;

   logic [SUM_BITS-1:0]      sum;
   logic [VALUE_BITS-1:0]    stencil;
   logic [VALUE_BITS-1:0]    first_value;
   logic [VALUE_BITS-1:0]    increase;
   logic [VALUE_BITS-1:0]    running_max_in;
   logic [1:0]               s1_push_n;
   logic [QCOUNT_BITS:0]     reserve;

   push_type                 push;
   result_type               first_item;
   result_type               second_item;
   result_type               rsp_item;
   logic [QCOUNT_BITS-1:0]   q_count;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= CFG_COLS_BITS'(MAX_COLS);
         grid_rows_ff    <= ROW_BITS'(64);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS: grid_columns_ff <= csr_data[CFG_COLS_BITS-1:0];
            CSR_GRID_ROWS:    grid_rows_ff    <= csr_data[ROW_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      if (grid_columns_ff < CFG_COLS_BITS'(MIN_COLS)) begin
         cols_eff = COLS_EFF_BITS'(MIN_COLS);
      end else if (grid_columns_ff > CFG_COLS_BITS'(MAX_COLS)) begin
         cols_eff = COLS_EFF_BITS'(MAX_COLS);
      end else begin
         cols_eff = COLS_EFF_BITS'(grid_columns_ff);
      end
      rows_eff = (grid_rows_ff < ROW_BITS'(MIN_ROWS)) ? ROW_BITS'(MIN_ROWS) : grid_rows_ff;
   end

   // position decode for the item at the input
   assign accept    = req_valid && !req_stall;
   assign last_row  = row_count_ff >= rows_eff - 1'b1;
   assign row_end   = COLS_EFF_BITS'(col_count_ff) >= cols_eff - 1'b1;
   assign frame_end = last_row && row_end;
   assign has_first = (row_count_ff != '0);
   assign er        = row_count_ff - 1'b1;
   assign interior  = has_first && (er != '0) && (er <= rows_eff - ROW_BITS'(2))
                      && (col_count_ff != '0)
                      && (COLS_EFF_BITS'(col_count_ff) <= cols_eff - COLS_EFF_BITS'(2));
   assign next_col  = row_end ? '0 : col_count_ff + 1'b1;

   // read one column ahead of the next item so its right neighbor is ready
   assign rd_addr = (accept ? next_col : col_count_ff) + 1'b1;
   assign old_mid = (col_count_ff == '0) ? col0_ff : cur_mid_ff;

   assign wr_pair.upper  = old_mid;
   assign wr_pair.middle = req_cell_value;

   hjs_ram #(
      .WIDTH($bits(line_pair_type)),
      .DEPTH(MAX_COLS)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(col_count_ff),
      .wr_data(wr_pair),
      .rd_addr(rd_addr),
      .rd_data(rd_pair)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= next_col;
         if (row_end) begin
            row_count_ff <= last_row ? '0 : row_count_ff + 1'b1;
         end
      end
   end

   // operand capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_up_ff   <= rd_pair.upper;
         cur_mid_ff  <= rd_pair.middle;
         left_ff     <= old_mid;
         if (col_count_ff == '0) begin
            col0_ff <= req_cell_value;
         end
         s1_first_ff     <= has_first;
         s1_second_ff    <= last_row;
         s1_interior_ff  <= interior;
         s1_frame_end_ff <= frame_end;
         s1_up_ff        <= cur_up_ff;
         s1_left_ff      <= left_ff;
         s1_right_ff     <= rd_pair.middle;
         s1_x_ff         <= req_cell_value;
         s1_old_ff       <= old_mid;
         s1_row_ff       <= row_count_ff;
         s1_col_ff       <= col_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   // stencil and increase tracking
   always_comb begin
      sum = SUM_BITS'(s1_up_ff) + SUM_BITS'(s1_x_ff)
          + SUM_BITS'(s1_left_ff) + SUM_BITS'(s1_right_ff);
      stencil     = sum[SUM_BITS-1:2];
      first_value = s1_interior_ff ? stencil : s1_old_ff;
      increase    = stencil - s1_old_ff;
      running_max_in = running_max_ff;
      if (s1_valid_ff && s1_first_ff && s1_interior_ff && (stencil > s1_old_ff)
          && (increase > running_max_ff)) begin
         running_max_in = increase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_max_ff <= '0;
      end else if (s1_valid_ff) begin
         running_max_ff <= s1_frame_end_ff ? '0 : running_max_in;
      end
   end

   always_comb begin
      push.first_valid  = s1_valid_ff && s1_first_ff;
      push.second_valid = s1_valid_ff && s1_second_ff;

      first_item.new_value    = first_value;
      first_item.out_row      = s1_row_ff - 1'b1;
      first_item.out_col      = s1_col_ff;
      first_item.frame_last   = 1'b0;
      first_item.max_increase = '0;

      second_item.new_value    = s1_x_ff;
      second_item.out_row      = s1_row_ff;
      second_item.out_col      = s1_col_ff;
      second_item.frame_last   = s1_frame_end_ff;
      second_item.max_increase = s1_frame_end_ff ? running_max_in : '0;
   end

   hjs_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .first_item (first_item),
      .second_item(second_item),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .count      (q_count)
   );

   // room for what the item in flight and one more item can add
   assign s1_push_n = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign reserve   = (QCOUNT_BITS+1)'(q_count) + (QCOUNT_BITS+1)'(s1_push_n);
   assign req_stall = reserve > (QCOUNT_BITS+1)'(QUEUE_DEPTH - 2);

   assign rsp_new_value    = rsp_item.new_value;
   assign rsp_out_row      = rsp_item.out_row;
   assign rsp_out_col      = rsp_item.out_col;
   assign rsp_frame_last   = rsp_item.frame_last;
   assign rsp_max_increase = rsp_item.max_increase;

`ifndef SYNTHESIS
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && row_end |=> col_count_ff == '0)
      else $error("column count did not wrap at row end");

   a_max_clear: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_frame_end_ff |=> running_max_ff == '0)
      else $error("running max not cleared at frame end");

   a_first_result: assert property (@(posedge clock) disable iff (reset)
      accept && (row_count_ff != '0) |=> s1_valid_ff && push.first_valid)
      else $error("item past the first row produced no result");
`endif

endmodule

// ===== sv/hjs_ram.sv =====
module hjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hjs_rsp_queue.sv =====
module hjs_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  hjs_pkg::push_type              push,
   input  hjs_pkg::result_type            first_item,
   input  hjs_pkg::result_type            second_item,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output hjs_pkg::result_type            rsp_item,
   output logic [hjs_pkg::QCOUNT_BITS-1:0] count
);
   import hjs_pkg::*;

   result_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QCOUNT_BITS-1:0] count_ff;
   logic [QPTR_BITS-1:0]   second_ptr;
   logic [1:0]             push_n;
   logic                   pop;

   assign pop        = rsp_valid && !rsp_stall;
   assign push_n     = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign second_ptr = wr_ptr_ff + QPTR_BITS'(push.first_valid);

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entries_ff[wr_ptr_ff] <= first_item;
      end
      if (push.second_valid) begin
         entries_ff[second_ptr] <= second_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(push_n);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCOUNT_BITS'(push_n) - QCOUNT_BITS'(pop);
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && !push.first_valid && !push.second_valid
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("result queue count lost a pop");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");
`endif

endmodule
